FILE: design/tpae_pkg.sv
// Package for the tape pulse audio encoder.
// Holds the register indexes, opcodes, mode codes and the structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpae_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PILOT_HALF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HALF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HALF    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_SAMPLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_SAMPLE = 3'd6;

  localparam logic [7:0] RST_PILOT_HALF  = 8'd27;
  localparam logic [7:0] RST_SYNC_FIRST  = 8'd8;
  localparam logic [7:0] RST_SYNC_SECOND = 8'd9;
  localparam logic [7:0] RST_ZERO_HALF   = 8'd11;
  localparam logic [7:0] RST_ONE_HALF    = 8'd22;
  localparam logic [7:0] RST_LOW_SAMPLE  = 8'd127;
  localparam logic [7:0] RST_HIGH_SAMPLE = 8'd254;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_PILOT = 3'd1;
  localparam logic [2:0] OP_SYNC  = 3'd2;
  localparam logic [2:0] OP_DATA  = 3'd3;
  localparam logic [2:0] OP_PAUSE = 3'd4;

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_PILOT = 3'd1;
  localparam logic [2:0] MODE_SYNC  = 3'd2;
  localparam logic [2:0] MODE_DATA  = 3'd3;
  localparam logic [2:0] MODE_PAUSE = 3'd4;

  localparam int unsigned SAMPLES_W = 22;

  typedef struct packed {
    logic [7:0] pilot_half_samples;
    logic [7:0] sync_first_samples;
    logic [7:0] sync_second_samples;
    logic [7:0] zero_half_samples;
    logic [7:0] one_half_samples;
    logic [7:0] low_sample;
    logic [7:0] high_sample;
  } tpae_cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] pilot_count;
    logic [7:0]  data_byte;
    logic [15:0] pause_ms;
  } tpae_cmd_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       sample_valid;
    logic       busy_res;
    logic       rejected;
  } tpae_res_t;

endpackage

`default_nettype wire

FILE: design/tpae_ifs.sv
// Valid/ready channel interfaces for the tape pulse audio encoder.
// Command channel in, sample result channel out. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tpae_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] pilot_count;
  logic [7:0]  data_byte;
  logic [15:0] pause_ms;

  modport source (output valid, output opcode, output pilot_count, output data_byte,
                  output pause_ms, input ready);
  modport sink   (input valid, input opcode, input pilot_count, input data_byte,
                  input pause_ms, output ready);
endinterface

interface tpae_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       sample_valid;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, output sample, output sample_valid, output busy_res,
                  output rejected, input ready);
  modport sink   (input valid, input sample, input sample_valid, input busy_res,
                  input rejected, output ready);
endinterface

`default_nettype wire

FILE: design/tpae_cfg_regs.sv
// Configuration register file of the tape pulse audio encoder.
// Seven 8-bit write-only registers; depends on tpae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpae_cfg_regs (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [tpae_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [tpae_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tpae_pkg::tpae_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pilot_half_samples  <= tpae_pkg::RST_PILOT_HALF;
      cfg.sync_first_samples  <= tpae_pkg::RST_SYNC_FIRST;
      cfg.sync_second_samples <= tpae_pkg::RST_SYNC_SECOND;
      cfg.zero_half_samples   <= tpae_pkg::RST_ZERO_HALF;
      cfg.one_half_samples    <= tpae_pkg::RST_ONE_HALF;
      cfg.low_sample          <= tpae_pkg::RST_LOW_SAMPLE;
      cfg.high_sample         <= tpae_pkg::RST_HIGH_SAMPLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpae_pkg::REG_PILOT_HALF:  cfg.pilot_half_samples  <= cfg_data;
        tpae_pkg::REG_SYNC_FIRST:  cfg.sync_first_samples  <= cfg_data;
        tpae_pkg::REG_SYNC_SECOND: cfg.sync_second_samples <= cfg_data;
        tpae_pkg::REG_ZERO_HALF:   cfg.zero_half_samples   <= cfg_data;
        tpae_pkg::REG_ONE_HALF:    cfg.one_half_samples    <= cfg_data;
        tpae_pkg::REG_LOW_SAMPLE:  cfg.low_sample          <= cfg_data;
        tpae_pkg::REG_HIGH_SAMPLE: cfg.high_sample         <= cfg_data;
        default: ;  // index beyond the register list: write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/tpae_engine.sv
// Command/tick engine of the tape pulse audio encoder: mode, level and counters.
// Updates state for one command per step and forms its result; depends on tpae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpae_engine (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  tpae_pkg::tpae_cmd_t  cmd,
  input  tpae_pkg::tpae_cfg_t  cfg,
  output logic                 res_valid,
  output tpae_pkg::tpae_res_t  res
);

  localparam int unsigned SW = tpae_pkg::SAMPLES_W;

  logic          signal_level, signal_level_next;
  logic [2:0]    mode, mode_next;
  logic [15:0]   pulses_left, pulses_left_next;
  logic [SW-1:0] samples_left, samples_left_next;
  logic [7:0]    bit_shift, bit_shift_next;
  logic [3:0]    bit_count, bit_count_next;
  logic          second_pulse, second_pulse_next;

  logic [SW-1:0] sl_dec;
  logic [15:0]   pl_dec;
  logic [3:0]    bc_dec;
  logic [7:0]    shifted;
  logic [31:0]   div_prod;
  logic [SW-1:0] pause_n;
  logic [SW-1:0] ms_ext;

  function automatic logic [SW-1:0] width_of(input logic [7:0] w);
    return (w == 8'd0) ? SW'(1) : {{(SW-8){1'b0}}, w};
  endfunction

  function automatic logic [SW-1:0] bit_width(input logic [7:0] shift_val,
                                              input tpae_pkg::tpae_cfg_t c);
    return shift_val[7] ? width_of(c.one_half_samples) : width_of(c.zero_half_samples);
  endfunction

  // ms*441/10 = ms*44 + ms/10; ms/10 by reciprocal, exact over 16 bits
  assign ms_ext   = {{(SW-16){1'b0}}, cmd.pause_ms};
  assign div_prod = 32'(cmd.pause_ms) * 32'd52429;
  assign pause_n  = (ms_ext << 5) + (ms_ext << 3) + (ms_ext << 2)
                  + {{(SW-13){1'b0}}, div_prod[31:19]};

  assign sl_dec  = samples_left - SW'(1);
  assign pl_dec  = pulses_left - 16'd1;
  assign bc_dec  = bit_count - 4'd1;
  assign shifted = {bit_shift[6:0], 1'b0};

  always_comb begin
    signal_level_next = signal_level;
    mode_next         = mode;
    pulses_left_next  = pulses_left;
    samples_left_next = samples_left;
    bit_shift_next    = bit_shift;
    bit_count_next    = bit_count;
    second_pulse_next = second_pulse;
    res_valid         = 1'b0;
    res               = '0;

    if (cmd.opcode == tpae_pkg::OP_TICK) begin
      res_valid = 1'b1;
      if (mode != tpae_pkg::MODE_IDLE) begin
        res.sample_valid = 1'b1;
        if (mode == tpae_pkg::MODE_PAUSE || !signal_level) res.sample = cfg.low_sample;
        else res.sample = cfg.high_sample;
        samples_left_next = sl_dec;
        if (sl_dec == '0) begin
          if (mode == tpae_pkg::MODE_PAUSE) begin
            mode_next = tpae_pkg::MODE_IDLE;
          end else begin
            // end of a pulse: level flips, then the next pulse or the end
            signal_level_next = ~signal_level;
            unique case (mode)
              tpae_pkg::MODE_PILOT: begin
                pulses_left_next = pl_dec;
                if (pl_dec == 16'd0) mode_next = tpae_pkg::MODE_IDLE;
                else samples_left_next = width_of(cfg.pilot_half_samples);
              end
              tpae_pkg::MODE_SYNC: begin
                if (!second_pulse) begin
                  second_pulse_next = 1'b1;
                  samples_left_next = width_of(cfg.sync_second_samples);
                end else begin
                  second_pulse_next = 1'b0;
                  mode_next = tpae_pkg::MODE_IDLE;
                end
              end
              tpae_pkg::MODE_DATA: begin
                if (!second_pulse) begin
                  second_pulse_next = 1'b1;
                  samples_left_next = bit_width(bit_shift, cfg);
                end else begin
                  second_pulse_next = 1'b0;
                  bit_shift_next    = shifted;
                  bit_count_next    = bc_dec;
                  if (bc_dec == 4'd0) mode_next = tpae_pkg::MODE_IDLE;
                  else samples_left_next = bit_width(shifted, cfg);
                end
              end
              default: mode_next = tpae_pkg::MODE_IDLE;
            endcase
          end
        end
        res.busy_res = (mode_next != tpae_pkg::MODE_IDLE);
      end
    end else if (cmd.opcode == tpae_pkg::OP_PILOT || cmd.opcode == tpae_pkg::OP_SYNC ||
                 cmd.opcode == tpae_pkg::OP_DATA || cmd.opcode == tpae_pkg::OP_PAUSE) begin
      if (mode != tpae_pkg::MODE_IDLE) begin
        res_valid    = 1'b1;
        res.rejected = 1'b1;
        res.busy_res = 1'b1;
      end else begin
        second_pulse_next = 1'b0;
        unique case (cmd.opcode)
          tpae_pkg::OP_PILOT: begin
            if (cmd.pilot_count != 16'd0) begin
              pulses_left_next  = cmd.pilot_count;
              samples_left_next = width_of(cfg.pilot_half_samples);
              mode_next         = tpae_pkg::MODE_PILOT;
            end
          end
          tpae_pkg::OP_SYNC: begin
            samples_left_next = width_of(cfg.sync_first_samples);
            mode_next         = tpae_pkg::MODE_SYNC;
          end
          tpae_pkg::OP_DATA: begin
            bit_shift_next    = cmd.data_byte;
            bit_count_next    = 4'd8;
            samples_left_next = bit_width(cmd.data_byte, cfg);
            mode_next         = tpae_pkg::MODE_DATA;
          end
          default: begin
            if (pause_n != '0) begin
              samples_left_next = pause_n;
              mode_next         = tpae_pkg::MODE_PAUSE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      signal_level <= 1'b0;
      mode         <= tpae_pkg::MODE_IDLE;
      pulses_left  <= '0;
      samples_left <= '0;
      bit_shift    <= '0;
      bit_count    <= '0;
      second_pulse <= 1'b0;
    end else if (step) begin
      signal_level <= signal_level_next;
      mode         <= mode_next;
      pulses_left  <= pulses_left_next;
      samples_left <= samples_left_next;
      bit_shift    <= bit_shift_next;
      bit_count    <= bit_count_next;
      second_pulse <= second_pulse_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/tape_pulse_audio_encoder_top.sv
// Top level of the tape pulse audio encoder: input register, engine, result register.
// Depends on tpae_pkg, tpae_ifs, tpae_cfg_regs and tpae_engine.
//
// Usage:
//  - cmd carries one transaction per command or tick: opcode 0 is a tick, 1 pilot,
//    2 sync, 3 data byte, 4 pause. Opcodes 5 to 7 are dropped silently.
//  - res returns at most one transaction per cmd transaction: every tick yields
//    one, a command yields one only when it is rejected because the block is busy.
//  - A cmd transaction is registered in the input register when accepted; its result
//    is loaded into the result register when the engine steps and then shows on res.
//  - Throughput: one cmd transaction per cycle while res takes results; the engine
//    forms its result combinationally between the input and result registers.
//  - When res stalls, the result register holds and the input register fills;
//    cmd.ready then drops until res takes its transaction.
//  - Configuration: cfg_we/cfg_index/cfg_data write the seven 8-bit registers;
//    the user must do so only while no transaction is in flight (not enforced).
//  - Reset (rst, synchronous): registers go to their defaults, level low, mode idle,
//    both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module tape_pulse_audio_encoder_top (
  input  wire                            clk,
  input  wire                            rst,
  tpae_cmd_if.sink                       cmd,
  tpae_res_if.source                     res,
  input  wire                            cfg_we,
  input  wire [tpae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [tpae_pkg::CFG_DATA_W-1:0] cfg_data
);

  tpae_pkg::tpae_cfg_t cfg;
  tpae_pkg::tpae_cmd_t in_reg;
  tpae_pkg::tpae_res_t eng_res;
  tpae_pkg::tpae_res_t out_reg;
  logic                in_valid;
  logic                out_valid;
  logic                eng_res_valid;
  logic                advance;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  tpae_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpae_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .cmd       (in_reg),
    .cfg       (cfg),
    .res_valid (eng_res_valid),
    .res       (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_reg.opcode      <= cmd.opcode;
      in_reg.pilot_count <= cmd.pilot_count;
      in_reg.data_byte   <= cmd.data_byte;
      in_reg.pause_ms    <= cmd.pause_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= eng_res_valid;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && eng_res_valid) begin
      out_reg <= eng_res;
    end
  end

  assign res.valid        = out_valid;
  assign res.sample       = out_reg.sample;
  assign res.sample_valid = out_reg.sample_valid;
  assign res.busy_res     = out_reg.busy_res;
  assign res.rejected     = out_reg.rejected;

`ifndef SYNTHESIS
  // a held item is never lost while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("input register dropped an item");

  // a rejected command never carries a sample and always reports busy
  a_reject_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.rejected) |-> (!out_reg.sample_valid && out_reg.busy_res))
    else $error("rejected result with bad fields");

  // a new result only appears after an item left the input register
  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without an engine step");

  // back-pressure on cmd only when both registers are full
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (in_valid && out_valid && !res.ready))
    else $error("cmd stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

FILE: verif/tape_pulse_audio_encoder_top_tb.sv
// Testbench for tape_pulse_audio_encoder_top: directed and random command/tick traffic
// with an in-bench sample predictor and a scoreboard on the result channel.
// Depends on tpae_pkg, tpae_ifs and the design top level.
`timescale 1ns / 1ps

module tape_pulse_audio_encoder_top_tb;
  import tpae_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tpae_cmd_if cmd_ch ();
  tpae_res_if res_ch ();

  tape_pulse_audio_encoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  int src_idle_pct  = 14;
  int sink_idle_pct = 48;
  int hold_request  = 0;
  int error_count   = 0;

  tpae_res_t expected_samples [$];

  // Encoder state as predicted from accepted transactions
  logic [7:0]  cfg_shadow [7];
  logic        enc_level;
  logic [2:0]  enc_mode;
  logic [15:0] enc_pulses;
  logic [21:0] enc_samples;
  logic [7:0]  enc_shift;
  logic [3:0]  enc_bits;
  logic        enc_second;

  function automatic logic [21:0] width_of(input logic [2:0] idx);
    return (cfg_shadow[idx] == 8'd0) ? 22'd1 : {14'd0, cfg_shadow[idx]};
  endfunction

  function automatic logic [21:0] bit_width();
    return enc_shift[7] ? width_of(REG_ONE_HALF) : width_of(REG_ZERO_HALF);
  endfunction

  // Returns 1 when the transaction yields a result, which is placed in r.
  function automatic bit encode_step(input tpae_cmd_t c, output tpae_res_t r);
    logic [31:0] n;
    r = '0;
    if (c.opcode >= OP_PILOT && c.opcode <= OP_PAUSE) begin
      if (enc_mode != MODE_IDLE) begin
        r.busy_res = 1'b1;
        r.rejected = 1'b1;
        return 1'b1;
      end
      enc_second = 1'b0;
      case (c.opcode)
        OP_PILOT: begin
          if (c.pilot_count != 16'd0) begin
            enc_pulses  = c.pilot_count;
            enc_samples = width_of(REG_PILOT_HALF);
            enc_mode    = MODE_PILOT;
          end
        end
        OP_SYNC: begin
          enc_samples = width_of(REG_SYNC_FIRST);
          enc_mode    = MODE_SYNC;
        end
        OP_DATA: begin
          enc_shift   = c.data_byte;
          enc_bits    = 4'd8;
          enc_samples = bit_width();
          enc_mode    = MODE_DATA;
        end
        default: begin
          n = (32'(c.pause_ms) * 32'd441) / 32'd10;
          if (n != 32'd0) begin
            enc_samples = n[21:0];
            enc_mode    = MODE_PAUSE;
          end
        end
      endcase
      return 1'b0;
    end
    if (c.opcode != OP_TICK) return 1'b0;
    if (enc_mode == MODE_IDLE) return 1'b1;

    r.sample = (enc_mode == MODE_PAUSE || !enc_level) ? cfg_shadow[REG_LOW_SAMPLE]
                                                      : cfg_shadow[REG_HIGH_SAMPLE];
    r.sample_valid = 1'b1;
    enc_samples = enc_samples - 22'd1;
    if (enc_samples == 22'd0) begin
      if (enc_mode == MODE_PAUSE) begin
        enc_mode = MODE_IDLE;
      end else begin
        // end of pulse: level flips, next pulse width read now
        enc_level = ~enc_level;
        case (enc_mode)
          MODE_PILOT: begin
            enc_pulses = enc_pulses - 16'd1;
            if (enc_pulses == 16'd0) enc_mode = MODE_IDLE;
            else enc_samples = width_of(REG_PILOT_HALF);
          end
          MODE_SYNC: begin
            if (!enc_second) begin
              enc_second  = 1'b1;
              enc_samples = width_of(REG_SYNC_SECOND);
            end else begin
              enc_second = 1'b0;
              enc_mode   = MODE_IDLE;
            end
          end
          MODE_DATA: begin
            if (!enc_second) begin
              enc_second  = 1'b1;
              enc_samples = bit_width();
            end else begin
              enc_second = 1'b0;
              enc_shift  = enc_shift << 1;
              enc_bits   = enc_bits - 4'd1;
              if (enc_bits == 4'd0) enc_mode = MODE_IDLE;
              else enc_samples = bit_width();
            end
          end
          default: enc_mode = MODE_IDLE;
        endcase
      end
    end
    r.busy_res = (enc_mode != MODE_IDLE);
    return 1'b1;
  endfunction

  function automatic tpae_cmd_t make_cmd(input logic [2:0] op, input logic [15:0] cnt,
                                         input logic [7:0] byte_v, input logic [15:0] ms);
    tpae_cmd_t c;
    c.opcode      = op;
    c.pilot_count = cnt;
    c.data_byte   = byte_v;
    c.pause_ms    = ms;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= 40)
      $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic send_item(input tpae_cmd_t c);
    tpae_res_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.opcode      <= c.opcode;
    cmd_ch.pilot_count <= c.pilot_count;
    cmd_ch.data_byte   <= c.data_byte;
    cmd_ch.pause_ms    <= c.pause_ms;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (encode_step(c, r)) expected_samples = {expected_samples, r};
  endtask

  // Ticks until the running command is done, then one idle tick.
  task automatic tick_until_idle();
    while (enc_mode != MODE_IDLE) send_item(make_cmd(OP_TICK, 16'd0, 8'd0, 16'd0));
    send_item(make_cmd(OP_TICK, 16'd0, 8'd0, 16'd0));
  endtask

  task automatic drain_pipeline();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_shadow[idx] = val;
  endtask

  task automatic load_config(input logic [7:0] pilot, sync1, sync2, zero, one, lo, hi);
    write_reg(REG_PILOT_HALF, pilot);
    write_reg(REG_SYNC_FIRST, sync1);
    write_reg(REG_SYNC_SECOND, sync2);
    write_reg(REG_ZERO_HALF, zero);
    write_reg(REG_ONE_HALF, one);
    write_reg(REG_LOW_SAMPLE, lo);
    write_reg(REG_HIGH_SAMPLE, hi);
    cfg_we <= 1'b0;
  endtask

  task automatic load_reset_config();
    load_config(RST_PILOT_HALF, RST_SYNC_FIRST, RST_SYNC_SECOND, RST_ZERO_HALF,
                RST_ONE_HALF, RST_LOW_SAMPLE, RST_HIGH_SAMPLE);
  endtask

  // Idle ticks, unused opcodes and empty commands leave the block idle.
  task automatic test_idle_behavior();
    send_item(make_cmd(OP_TICK, 16'd0, 8'd0, 16'd0));
    send_item(make_cmd(3'd5, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_item(make_cmd(3'd6, 16'd0, 8'd0, 16'd0));
    send_item(make_cmd(3'd7, 16'h8000, 8'h80, 16'h8000));
    send_item(make_cmd(OP_PILOT, 16'd0, 8'd0, 16'd0));
    send_item(make_cmd(OP_PAUSE, 16'd0, 8'd0, 16'd0));
    send_item(make_cmd(OP_TICK, 16'd0, 8'd0, 16'd0));
    drain_pipeline();
  endtask

  task automatic test_each_command();
    send_item(make_cmd(OP_PILOT, 16'd3, 8'd0, 16'd0));
    tick_until_idle();
    send_item(make_cmd(OP_SYNC, 16'd0, 8'd0, 16'd0));
    tick_until_idle();
    send_item(make_cmd(OP_DATA, 16'd0, 8'hA5, 16'd0));
    tick_until_idle();
    send_item(make_cmd(OP_PAUSE, 16'd0, 8'd0, 16'd1));
    tick_until_idle();
    drain_pipeline();
  endtask

  task automatic test_busy_rejects();
    send_item(make_cmd(OP_SYNC, 16'd0, 8'd0, 16'd0));
    send_item(make_cmd(OP_PILOT, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_item(make_cmd(OP_DATA, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_item(make_cmd(OP_PAUSE, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_item(make_cmd(OP_SYNC, 16'd0, 8'd0, 16'd0));
    send_item(make_cmd(3'd7, 16'd0, 8'd0, 16'd0));
    tick_until_idle();
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    // zero widths behave as one sample
    load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    send_item(make_cmd(OP_DATA, 16'd0, 8'h5A, 16'd0));
    tick_until_idle();
    send_item(make_cmd(OP_PILOT, 16'd2, 8'd0, 16'd0));
    tick_until_idle();
    send_item(make_cmd(OP_SYNC, 16'd0, 8'd0, 16'd0));
    tick_until_idle();
    drain_pipeline();
    load_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
    send_item(make_cmd(OP_PILOT, 16'd1, 8'd0, 16'd0));
    send_item(make_cmd(OP_PAUSE, 16'd0, 8'd0, 16'd1));
    tick_until_idle();
    send_item(make_cmd(OP_PAUSE, 16'd0, 8'd0, 16'd1));
    tick_until_idle();
    drain_pipeline();
  endtask

  // New widths apply from the next pulse start of a running command.
  task automatic test_mid_command_change();
    load_reset_config();
    send_item(make_cmd(OP_PILOT, 16'd4, 8'd0, 16'd0));
    repeat (10) send_item(make_cmd(OP_TICK, 16'd0, 8'd0, 16'd0));
    drain_pipeline();
    write_reg(REG_PILOT_HALF, 8'd3);
    write_reg(REG_HIGH_SAMPLE, 8'd0);
    cfg_we <= 1'b0;
    tick_until_idle();
    drain_pipeline();
  endtask

  task automatic test_long_pilot();
    load_config(8'd1, RST_SYNC_FIRST, RST_SYNC_SECOND, RST_ZERO_HALF, RST_ONE_HALF,
                RST_LOW_SAMPLE, RST_HIGH_SAMPLE);
    send_item(make_cmd(OP_PILOT, 16'd100, 8'd0, 16'd0));
    tick_until_idle();
    drain_pipeline();
    load_reset_config();
  endtask

  // Result side holds off while ticks keep coming, so the input stalls.
  task automatic test_output_stall();
    send_item(make_cmd(OP_PAUSE, 16'd0, 8'd0, 16'd3));
    hold_request++;
    repeat (60) send_item(make_cmd(OP_TICK, 16'd0, 8'd0, 16'd0));
    tick_until_idle();
    drain_pipeline();
  endtask

  function automatic logic [7:0] rand_width();
    return ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 5));
  endfunction

  task automatic send_random_item();
    tpae_cmd_t c;
    int pick;
    c.opcode      = OP_TICK;
    c.pilot_count = 16'($urandom_range(16'hFFFF));
    c.data_byte   = 8'($urandom_range(8'hFF));
    c.pause_ms    = 16'($urandom_range(16'hFFFF));
    pick = $urandom_range(99);
    if (enc_mode == MODE_IDLE) begin
      if (pick < 10) c.opcode = OP_TICK;
      else if (pick < 14) c.opcode = 3'($urandom_range(5, 7));
      else if (pick < 34) begin
        c.opcode      = OP_PILOT;
        c.pilot_count = 16'($urandom_range(6));
      end else if (pick < 50) c.opcode = OP_SYNC;
      else if (pick < 82) c.opcode = OP_DATA;
      else begin
        c.opcode   = OP_PAUSE;
        c.pause_ms = 16'($urandom_range(2));
      end
    end else begin
      // mostly ticks; some commands that must be rejected, some unused opcodes
      if (pick < 86) c.opcode = OP_TICK;
      else if (pick < 90) c.opcode = 3'($urandom_range(5, 7));
      else c.opcode = 3'($urandom_range(OP_PILOT, OP_PAUSE));
    end
    send_item(c);
  endtask

  task automatic test_random_traffic(input int items, input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 135 == 0) begin
        drain_pipeline();
        load_config(rand_width(), rand_width(), rand_width(), rand_width(), rand_width(),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      send_random_item();
    end
    drain_pipeline();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: checks each accepted transaction, then picks next ready.
  initial begin : result_sink
    int hold_left;
    int seen_request;
    tpae_res_t want;
    hold_left    = 0;
    seen_request = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("result with nothing expected", 1, 0);
        end else begin
          want = expected_samples.pop_front();
          if (res_ch.sample !== want.sample)
            report_mismatch("sample", res_ch.sample, want.sample);
          if (res_ch.sample_valid !== want.sample_valid)
            report_mismatch("sample_valid", res_ch.sample_valid, want.sample_valid);
          if (res_ch.busy_res !== want.busy_res)
            report_mismatch("busy_res", res_ch.busy_res, want.busy_res);
          if (res_ch.rejected !== want.rejected)
            report_mismatch("rejected", res_ch.rejected, want.rejected);
        end
      end
      if (hold_request != seen_request) begin
        seen_request = hold_request;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.opcode      <= OP_TICK;
    cmd_ch.pilot_count <= '0;
    cmd_ch.data_byte   <= '0;
    cmd_ch.pause_ms    <= '0;
    cfg_shadow[REG_PILOT_HALF]  = RST_PILOT_HALF;
    cfg_shadow[REG_SYNC_FIRST]  = RST_SYNC_FIRST;
    cfg_shadow[REG_SYNC_SECOND] = RST_SYNC_SECOND;
    cfg_shadow[REG_ZERO_HALF]   = RST_ZERO_HALF;
    cfg_shadow[REG_ONE_HALF]    = RST_ONE_HALF;
    cfg_shadow[REG_LOW_SAMPLE]  = RST_LOW_SAMPLE;
    cfg_shadow[REG_HIGH_SAMPLE] = RST_HIGH_SAMPLE;
    enc_level   = 1'b0;
    enc_mode    = MODE_IDLE;
    enc_pulses  = '0;
    enc_samples = '0;
    enc_shift   = '0;
    enc_bits    = '0;
    enc_second  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_idle_behavior();
    test_each_command();
    test_busy_rejects();
    test_register_extremes();
    test_mid_command_change();
    test_long_pilot();
    test_output_stall();
    test_random_traffic(180, 14, 48);
    test_random_traffic(180, 48, 14);
    test_random_traffic(180, 0, 0);
    drain_pipeline();

    if (error_count == 0) begin
      $display("tape_pulse_audio_encoder_top_tb passed");
    end else begin
      $display("tape_pulse_audio_encoder_top_tb failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tape_pulse_audio_encoder_top_tb failed");
    $finish;
  end

endmodule

FILE: tape_pulse_audio_encoder_top.f
design/tpae_pkg.sv
design/tpae_ifs.sv
design/tpae_cfg_regs.sv
design/tpae_engine.sv
design/tape_pulse_audio_encoder_top.sv
verif/tape_pulse_audio_encoder_top_tb.sv
